FILE: design/i2a_pkg.sv
// Shared types, constants and a helper function for the integer to ASCII formatter.
package i2a_pkg;

  localparam int ValueW   = 64;
  localparam int DecDigits = 20;
  localparam int BcdW     = 4 * DecDigits;
  localparam int HexDigits = 16;
  localparam int MinW     = 7;
  localparam int CharW    = 8;

  localparam logic [1:0] FUNC_SDEC = 2'd0;
  localparam logic [1:0] FUNC_UDEC = 2'd1;
  localparam logic [1:0] FUNC_HEXL = 2'd2;
  localparam logic [1:0] FUNC_HEXU = 2'd3;

  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_MINUS = 8'h2d;
  localparam logic [CharW-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CharW-1:0] CH_SPACE = 8'h20;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_LOWA  = 8'h61;
  localparam logic [CharW-1:0] CH_UPA   = 8'h41;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  // Status from the conversion unit back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } dd_stat_t;

  function automatic logic [CharW-1:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [CharW-1:0] base;
    base = upper ? CH_UPA : CH_LOWA;
    if (nib < 4'd10) begin
      digit_char = CH_ZERO + {4'b0, nib};
    end else begin
      digit_char = base + {4'b0, nib - 4'd10};
    end
  endfunction

endpackage

FILE: design/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter: request sequencer and character output.
//
// One request is formatted at a time and in_tready is low until its last character has been
// loaded into the output register. A decimal request first passes through the
// shift-and-add-3 converter (one bit a cycle), then strips leading zero digits (one digit a
// cycle), then emits its characters, one per cycle while the output is not stalled.
// Hex requests skip the converter but strip leading zero digits as well.
// The output register lets the next request enter while the final character still waits.
module integer_to_ascii_formatter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [63:0] value, [70:64] min_digits, [71] plus_sign, [72] space_sign,
  // [73] hex_prefix, [79:74] zero
  input  logic [79:0] in_tdata,
  // [1:0] func
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_char
  output logic [7:0]  out_tdata,
  output logic        out_tlast
);
  import i2a_pkg::*;

  localparam int NdW  = $clog2(DecDigits + 1);
  localparam int LenW = MinW - 1;

  state_t             state_r, state_nxt;
  logic [BcdW-1:0]    dig_r, dig_nxt;
  logic [NdW-1:0]     ndig_r, ndig_nxt;
  logic [LenW-1:0]    minlen_r, minlen_nxt;
  logic [LenW-1:0]    pad_r, pad_nxt;
  logic [1:0]         pre_r, pre_nxt;
  logic [CharW-1:0]   pre_char_r, pre_char_nxt;
  logic               hex_r, hex_nxt;
  logic               upper_r, upper_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CharW-1:0]   out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  logic [ValueW-1:0]  in_value;
  logic [MinW-1:0]    in_min;
  logic               in_plus, in_space, in_prefix;
  logic               in_neg, dd_start;
  logic [ValueW-1:0]  dd_mag;
  logic [LenW-1:0]    min_clamped, eff_min, ndig_ext;
  dd_stat_t           dd_stat;
  logic [BcdW-1:0]    dd_bcd;

  assign in_value  = in_tdata[63:0];
  assign in_min    = in_tdata[70:64];
  assign in_plus   = in_tdata[71];
  assign in_space  = in_tdata[72];
  assign in_prefix = in_tdata[73];

  assign in_tready = (state_r == S_IDLE);
  assign in_neg    = (in_tuser == FUNC_SDEC) && in_value[ValueW-1];
  assign dd_mag    = in_neg ? (~in_value + 1'b1) : in_value;
  assign dd_start  = in_tvalid && in_tready && !in_tuser[1];

  // Negative counts mean one digit; 63 saturates to 62.
  always_comb begin
    if (in_min[MinW-1] || in_min[LenW-1:0] == '0) begin
      min_clamped = LenW'(1);
    end else if (in_min[LenW-1:0] == '1) begin
      min_clamped = LenW'(62);
    end else begin
      min_clamped = in_min[LenW-1:0];
    end
  end

  assign eff_min  = (hex_r && minlen_r > LenW'(HexDigits)) ? LenW'(HexDigits) : minlen_r;
  assign ndig_ext = LenW'(ndig_r);

  i2a_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dd_start),
    .mag   (dd_mag),
    .stat  (dd_stat),
    .bcd   (dd_bcd)
  );

  always_comb begin
    state_nxt     = state_r;
    dig_nxt       = dig_r;
    ndig_nxt      = ndig_r;
    minlen_nxt    = minlen_r;
    pad_nxt       = pad_r;
    pre_nxt       = pre_r;
    pre_char_nxt  = pre_char_r;
    hex_nxt       = hex_r;
    upper_nxt     = upper_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          minlen_nxt = min_clamped;
          hex_nxt    = in_tuser[1];
          upper_nxt  = (in_tuser == FUNC_HEXU);
          if (in_tuser[1]) begin
            dig_nxt      = {in_value, {(BcdW-ValueW){1'b0}}};
            ndig_nxt     = NdW'(HexDigits);
            pre_nxt      = in_prefix ? 2'd2 : 2'd0;
            pre_char_nxt = CH_X;
            state_nxt    = S_SCAN;
          end else begin
            state_nxt = S_CONV;
            if (in_neg) begin
              pre_nxt      = 2'd1;
              pre_char_nxt = CH_MINUS;
            end else if (in_plus) begin
              pre_nxt      = 2'd1;
              pre_char_nxt = CH_PLUS;
            end else if (in_space) begin
              pre_nxt      = 2'd1;
              pre_char_nxt = CH_SPACE;
            end else begin
              pre_nxt      = 2'd0;
              pre_char_nxt = CH_SPACE;
            end
          end
        end
      end
      S_CONV: begin
        if (dd_stat.done) begin
          dig_nxt   = dd_bcd;
          ndig_nxt  = NdW'(DecDigits);
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Strip leading zero digits, always keeping at least one.
        if (dig_r[BcdW-1 -: 4] == 4'd0 && ndig_r > NdW'(1)) begin
          dig_nxt  = {dig_r[BcdW-5:0], 4'd0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          pad_nxt   = (eff_min > ndig_ext) ? (eff_min - ndig_ext) : '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          if (pre_r != 2'd0) begin
            out_char_nxt = (pre_r == 2'd2) ? CH_ZERO : pre_char_r;
            pre_nxt      = pre_r - 1'b1;
          end else if (pad_r != '0) begin
            out_char_nxt = CH_ZERO;
            pad_nxt      = pad_r - 1'b1;
          end else begin
            out_char_nxt = digit_char(dig_r[BcdW-1 -: 4], upper_r);
            dig_nxt      = {dig_r[BcdW-5:0], 4'd0};
            ndig_nxt     = ndig_r - 1'b1;
            if (ndig_r == NdW'(1)) begin
              out_last_nxt = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    ndig_r     <= ndig_nxt;
    minlen_r   <= minlen_nxt;
    pad_r      <= pad_nxt;
    pre_r      <= pre_nxt;
    pre_char_r <= pre_char_nxt;
    hex_r      <= hex_nxt;
    upper_r    <= upper_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: design/i2a_dabble.sv
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
module i2a_dabble (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [i2a_pkg::ValueW-1:0]    mag,
  output i2a_pkg::dd_stat_t             stat,
  output logic [i2a_pkg::BcdW-1:0]      bcd
);
  import i2a_pkg::*;

  localparam int CntW = $clog2(ValueW + 1);

  logic [BcdW-1:0]   bcd_r, bcd_nxt, corr;
  logic [ValueW-1:0] bin_r, bin_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  // Each BCD digit of five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        corr[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        corr[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bcd_nxt  = bcd_r;
    bin_nxt  = bin_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      bcd_nxt  = '0;
      bin_nxt  = mag;
      cnt_nxt  = CntW'(ValueW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      bcd_nxt = {corr[BcdW-2:0], bin_r[ValueW-1]};
      bin_nxt = {bin_r[ValueW-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
    bin_r <= bin_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign bcd       = bcd_r;

endmodule

FILE: design/i2a_checker.sv
// Port-level checker for the integer to ASCII formatter, bound to the top level.
module i2a_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  // A request stays in progress after acceptance, so ready drops once it is accepted.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("in_tready stayed high after a request was accepted");

  // Ready returns exactly when the final character has been loaded.
  a_ready_with_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_tready) |-> (out_tvalid && out_tlast))
    else $error("in_tready rose without a final character pending");

  // A pending character that is not the last means the request is still in flight.
  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> !in_tready)
    else $error("ready for a new request in the middle of a character run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled output character changed");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: bench/i2a_text_checker.sv
// Checker for the integer to ASCII formatter: predicts each request's text and compares output.
module i2a_text_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  output int          error_count,
  output int          pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } text_char_t;

  text_char_t expected_text[$];
  text_char_t want;
  int         errors = 0;

  // Formats one request and appends its characters to the expected text.
  function automatic void predict_text(input logic [79:0] data, input logic [1:0] func);
    logic [63:0]      value;
    logic [63:0]      mag;
    logic [6:0]       min_raw;
    logic             plus;
    logic             space;
    logic             prefix;
    logic [3:0]       nib;
    logic [CharW-1:0] text[$];
    logic [CharW-1:0] digits[$];
    int               width;
    bit               started;
    string            hex_set;
    value   = data[63:0];
    min_raw = data[70:64];
    plus    = data[71];
    space   = data[72];
    prefix  = data[73];
    started = 1'b0;
    // A negative minimum counts as zero; the count is kept within 1..62.
    width = min_raw[6] ? 0 : int'(min_raw);
    if (width > 62) width = 62;
    if (width < 1) width = 1;
    if (func == FUNC_SDEC || func == FUNC_UDEC) begin
      mag = value;
      if (func == FUNC_SDEC && value[63]) begin
        text.push_back(CH_MINUS);
        mag = 64'd0 - value;
      end else if (plus) begin
        text.push_back(CH_PLUS);
      end else if (space) begin
        text.push_back(CH_SPACE);
      end
      do begin
        digits.push_front(CH_ZERO + 8'(mag % 64'd10));
        mag = mag / 64'd10;
      end while (mag != 64'd0);
      for (int k = digits.size(); k < width; k++) text.push_back(CH_ZERO);
      foreach (digits[i]) text.push_back(digits[i]);
    end else begin
      hex_set = (func == FUNC_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
      if (prefix) begin
        text.push_back(CH_ZERO);
        text.push_back(CH_X);
      end
      for (int d = HexDigits - 1; d >= 0; d--) begin
        nib = value[d*4 +: 4];
        if (d + 1 <= width || nib != 4'd0) started = 1'b1;
        if (started) text.push_back(hex_set[nib]);
      end
    end
    foreach (text[i]) expected_text.push_back('{code: text[i], last: (i == text.size() - 1)});
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_text.size() == 0) begin
          $display("%0t: unexpected character, expected none, got %h last %b",
                   $time, out_tdata, out_tlast);
          errors++;
        end else begin
          want = expected_text.pop_front();
          if (out_tdata !== want.code) begin
            $display("%0t: character mismatch, expected %h, got %h",
                     $time, want.code, out_tdata);
            errors++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last marker mismatch, expected %b, got %b",
                     $time, want.last, out_tlast);
            errors++;
          end
        end
      end
      if (in_tvalid && in_tready) predict_text(in_tdata, in_tuser);
    end
    error_count   <= errors;
    pending_count <= expected_text.size();
  end

endmodule

FILE: bench/tb_integer_to_ascii_formatter.sv
// Testbench top for the integer to ASCII formatter: stimulus, watchdog and verdict.
module tb_integer_to_ascii_formatter;

  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  localparam int StallLimit = 4000;
  localparam int PhaseItems = 37;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  int          error_count;
  int          pending_count;
  int          sender_idle_pct = 0;
  int          sink_stall_pct  = 0;
  int          stall_cycles    = 0;

  integer_to_ascii_formatter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  i2a_text_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .error_count  (error_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  initial begin
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  task automatic send_request(input logic [63:0] value, input logic [1:0] func,
                              input logic [6:0] min_raw, input logic plus,
                              input logic space, input logic prefix);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, prefix, space, plus, min_raw, value};
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Holds the request side idle until every character in flight has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] p;
    p = 64'd1;
    case ($urandom_range(0, 5))
      0, 1: pick_value = {$urandom, $urandom};
      2: pick_value = 64'($urandom_range(0, 999));
      3: begin
        repeat ($urandom_range(0, 19)) p = p * 64'd10;
        pick_value = p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      4: pick_value = 64'd0 - 64'($urandom_range(1, 1000));
      default: pick_value = {1'b1, 63'd0} + 64'($urandom_range(0, 3)) - 64'd2;
    endcase
  endfunction

  function automatic logic [6:0] pick_min();
    case ($urandom_range(0, 4))
      0, 1, 2: pick_min = 7'($urandom_range(0, 5));
      3: pick_min = 7'($urandom_range(14, 22));
      default: pick_min = 7'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_request(64'd0, FUNC_SDEC, 7'd0, 1'b0, 1'b0, 1'b0);
    send_request({64{1'b1}}, FUNC_SDEC, 7'd0, 1'b0, 1'b0, 1'b0);
    // Most negative value: its magnitude does not fit the positive range.
    send_request({1'b1, 63'd0}, FUNC_SDEC, 7'd0, 1'b1, 1'b1, 1'b0);
    send_request({1'b0, {63{1'b1}}}, FUNC_SDEC, 7'd0, 1'b1, 1'b0, 1'b0);
    send_request(64'd5, FUNC_SDEC, 7'd0, 1'b0, 1'b1, 1'b1);
    send_request(64'd5, FUNC_SDEC, 7'd3, 1'b1, 1'b1, 1'b0);
    send_request(64'd0 - 64'd5, FUNC_SDEC, 7'd10, 1'b1, 1'b0, 1'b0);
    send_request({64{1'b1}}, FUNC_SDEC, 7'd62, 1'b0, 1'b0, 1'b0);
    send_request({64{1'b1}}, FUNC_UDEC, 7'd0, 1'b0, 1'b0, 1'b0);
    send_request(64'h8AC7230489E80000, FUNC_UDEC, 7'd0, 1'b0, 1'b0, 1'b0);
    // A minimum of 63 saturates so the text stays within 63 characters.
    send_request(64'd42, FUNC_UDEC, 7'd63, 1'b1, 1'b0, 1'b0);
    send_request(64'd7, FUNC_UDEC, 7'h7f, 1'b0, 1'b1, 1'b0);
    send_request(64'd0, FUNC_UDEC, 7'h40, 1'b0, 1'b0, 1'b1);
    send_request(64'd0, FUNC_HEXL, 7'd0, 1'b0, 1'b0, 1'b1);
    send_request({64{1'b1}}, FUNC_HEXL, 7'd0, 1'b0, 1'b0, 1'b1);
    send_request(64'hABCDEF0123456789, FUNC_HEXU, 7'd0, 1'b0, 1'b0, 1'b1);
    send_request(64'd1, FUNC_HEXU, 7'd63, 1'b1, 1'b1, 1'b0);
    send_request(64'h10, FUNC_HEXL, 7'd5, 1'b0, 1'b0, 1'b0);
    send_request({1'b1, 63'd0}, FUNC_HEXL, 7'h7f, 1'b1, 1'b0, 1'b1);
    send_request(64'd0, FUNC_HEXU, 7'd16, 1'b0, 1'b0, 1'b0);
    send_request(64'h00000000FEDCBA98, FUNC_HEXU, 7'd17, 1'b0, 1'b1, 1'b1);
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 62; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 62; end
        default: begin sender_idle_pct = 36; sink_stall_pct = 36; end
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        send_request(pick_value(), 2'($urandom_range(0, 3)), pick_min(),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
      end
      wait_drained();
    end

    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
